// ----- src/mck_pkg.sv -----
// Shared types, constants, character tables and microcode for the Morse keyer.
`timescale 1ns / 1ps

package mck_pkg;

  // Input transfer: one ASCII character and the end-of-message flag.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_message;
  } in_item_t;

  // Output transfer: one lamp segment.
  typedef struct packed {
    logic        lamp_on;
    logic [15:0] duration_ticks;
    logic        last;
  } out_item_t;

  // Configuration register indexes and reset values.
  localparam logic [1:0] REG_DOT_ON  = 2'd0;
  localparam logic [1:0] REG_DASH_ON = 2'd1;
  localparam logic [1:0] REG_GAP     = 2'd2;

  localparam logic [15:0] DotOnReset  = 16'd5000;
  localparam logic [15:0] DashOnReset = 16'd15000;
  localparam logic [15:0] GapReset    = 16'd10000;

  // Timing registers as seen by the datapath.
  typedef struct packed {
    logic [15:0] dot_on;
    logic [15:0] dash_on;
    logic [15:0] gap;
  } cfg_t;

  // Decoded character: element count and dash mask (bit i set means element i is a dash).
  typedef struct packed {
    logic [2:0] len;
    logic [4:0] pat;
  } morse_t;

  localparam logic [2:0] LetterLen [26] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [4:0] LetterPat [26] = '{
    5'd2, 5'd1, 5'd5, 5'd1, 5'd0, 5'd4, 5'd3, 5'd0, 5'd0, 5'd14, 5'd5, 5'd2, 5'd3,
    5'd1, 5'd7, 5'd6, 5'd11, 5'd2, 5'd0, 5'd1, 5'd4, 5'd8, 5'd6, 5'd9, 5'd13, 5'd3
  };
  localparam logic [4:0] DigitPat [10] = '{
    5'd31, 5'd30, 5'd28, 5'd24, 5'd16, 5'd0, 5'd1, 5'd3, 5'd7, 5'd15
  };

  localparam logic [2:0] DigitLen  = 3'd5;
  localparam logic [7:0] CharA     = 8'h41;
  localparam logic [7:0] CharZ     = 8'h5A;
  localparam logic [7:0] Char0     = 8'h30;
  localparam logic [7:0] Char9     = 8'h39;
  localparam logic [7:0] CharSpace = 8'h20;

  // Map a character to its Morse pattern; anything unknown has no elements.
  function automatic morse_t morse_decode(input logic [7:0] ch);
    morse_t     m;
    logic [7:0] off;
    m = '0;
    off = 8'h00;
    if (ch >= CharA && ch <= CharZ) begin
      off   = ch - CharA;
      m.len = LetterLen[off[4:0]];
      m.pat = LetterPat[off[4:0]];
    end else if (ch >= Char0 && ch <= Char9) begin
      off   = ch - Char0;
      m.len = DigitLen;
      m.pat = DigitPat[off[3:0]];
    end
    return m;
  endfunction

  // Microcode fields.
  typedef enum logic {
    DUR_ELEM,
    DUR_GAP
  } dur_sel_e;

  typedef enum logic [1:0] {
    LAST_NEVER,
    LAST_ALWAYS,
    LAST_ELEM_END,
    LAST_NO_EOM
  } last_sel_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_NO_LEN,
    COND_MORE_ELEM,
    COND_NOT_SPACE,
    COND_NO_EOM
  } cond_e;

  localparam int StepW = 4;

  // Named program addresses.
  localparam logic [StepW-1:0] S_WAIT      = 4'd0;
  localparam logic [StepW-1:0] S_CHECK_LEN = 4'd1;
  localparam logic [StepW-1:0] S_ELEM_ON   = 4'd2;
  localparam logic [StepW-1:0] S_ELEM_GAP  = 4'd3;
  localparam logic [StepW-1:0] S_CHK_SPACE = 4'd4;
  localparam logic [StepW-1:0] S_SPACE_0   = 4'd5;
  localparam logic [StepW-1:0] S_SPACE_1   = 4'd6;
  localparam logic [StepW-1:0] S_CHK_EOM   = 4'd7;
  localparam logic [StepW-1:0] S_EOM_0     = 4'd8;
  localparam logic [StepW-1:0] S_EOM_1     = 4'd9;
  localparam logic [StepW-1:0] S_DONE      = 4'd10;

  typedef struct packed {
    logic             emit;
    logic             lamp;
    dur_sel_e         dur;
    last_sel_e        last;
    cond_e            cond;
    logic [StepW-1:0] target;
    logic             inc_elem;
    logic             release_item;
  } uword_t;

  localparam uword_t UwordNop = '{
    emit: 1'b0, lamp: 1'b0, dur: DUR_GAP, last: LAST_NEVER, cond: COND_NEVER,
    target: S_WAIT, inc_elem: 1'b0, release_item: 1'b0
  };

  // Control store: one word per program step.
  function automatic uword_t ucode_rom(input logic [StepW-1:0] step);
    uword_t w;
    w = UwordNop;
    case (step)
      S_WAIT: begin
        w.cond   = COND_NO_ITEM;
        w.target = S_WAIT;
      end
      S_CHECK_LEN: begin
        w.cond   = COND_NO_LEN;
        w.target = S_CHK_SPACE;
      end
      S_ELEM_ON: begin
        w.emit = 1'b1;
        w.lamp = 1'b1;
        w.dur  = DUR_ELEM;
      end
      S_ELEM_GAP: begin
        w.emit     = 1'b1;
        w.last     = LAST_ELEM_END;
        w.cond     = COND_MORE_ELEM;
        w.target   = S_ELEM_ON;
        w.inc_elem = 1'b1;
      end
      S_CHK_SPACE: begin
        w.cond   = COND_NOT_SPACE;
        w.target = S_CHK_EOM;
      end
      S_SPACE_0: begin
        w.emit = 1'b1;
      end
      S_SPACE_1: begin
        w.emit = 1'b1;
        w.last = LAST_NO_EOM;
      end
      S_CHK_EOM: begin
        w.cond   = COND_NO_EOM;
        w.target = S_DONE;
      end
      S_EOM_0: begin
        w.emit = 1'b1;
      end
      S_EOM_1: begin
        w.emit = 1'b1;
        w.last = LAST_ALWAYS;
      end
      S_DONE: begin
        w.cond         = COND_ALWAYS;
        w.target       = S_WAIT;
        w.release_item = 1'b1;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = S_WAIT;
      end
    endcase
    return w;
  endfunction

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic item_full;
    logic len_zero;
    logic more_elem;
    logic is_space;
    logic eom;
    logic out_ready;
  } dp_status_t;

  // Gated control from the sequencer to the datapath.
  typedef struct packed {
    logic      emit;
    logic      lamp;
    dur_sel_e  dur;
    last_sel_e last;
    logic      inc_elem;
    logic      release_item;
  } dp_ctrl_t;

endpackage

// ----- src/mck_seq.sv -----
// Microcode sequencer: step counter, control store lookup and jump logic.
`timescale 1ns / 1ps

module mck_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mck_pkg::dp_status_t status_i,
  output mck_pkg::dp_ctrl_t   ctrl_o
);

  logic [mck_pkg::StepW-1:0] step_q, step_d;
  mck_pkg::uword_t           uw;
  logic                      advance;
  logic                      take_jump;

  // Fetch the control word of the current step.
  assign uw = mck_pkg::ucode_rom(step_q);

  // An emitting step waits until the output register can take the segment.
  assign advance = !uw.emit || status_i.out_ready;

  // Jump condition.
  always_comb begin
    case (uw.cond)
      mck_pkg::COND_NEVER:     take_jump = 1'b0;
      mck_pkg::COND_ALWAYS:    take_jump = 1'b1;
      mck_pkg::COND_NO_ITEM:   take_jump = !status_i.item_full;
      mck_pkg::COND_NO_LEN:    take_jump = status_i.len_zero;
      mck_pkg::COND_MORE_ELEM: take_jump = status_i.more_elem;
      mck_pkg::COND_NOT_SPACE: take_jump = !status_i.is_space;
      mck_pkg::COND_NO_EOM:    take_jump = !status_i.eom;
      default:                 take_jump = 1'b1;
    endcase
  end

  // Next step.
  always_comb begin
    step_d = step_q;
    if (advance) begin
      if (take_jump) begin
        step_d = uw.target;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= mck_pkg::S_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  // Side effects only take place on the cycle the step completes.
  assign ctrl_o.emit         = uw.emit && advance;
  assign ctrl_o.lamp         = uw.lamp;
  assign ctrl_o.dur          = uw.dur;
  assign ctrl_o.last         = uw.last;
  assign ctrl_o.inc_elem     = uw.inc_elem && advance;
  assign ctrl_o.release_item = uw.release_item && advance;

endmodule

// ----- src/mck_dpath.sv -----
// Keyer datapath: held character, element counter, duration select and output register.
`timescale 1ns / 1ps

module mck_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mck_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mck_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mck_pkg::out_item_t  out_data_o,
  input  mck_pkg::dp_ctrl_t   ctrl_i,
  output mck_pkg::dp_status_t status_o
);

  logic               item_full_q, item_full_d;
  mck_pkg::morse_t    morse_q;
  logic               space_q;
  logic               eom_q;
  logic [2:0]         elem_q, elem_d;
  logic               out_valid_q, out_valid_d;
  mck_pkg::out_item_t out_q;
  logic               in_fire;
  logic               more_elem;
  logic               is_dash;
  logic [15:0]        dur;
  logic               seg_last;

  // The character register is free again once its program has finished.
  assign in_stall_o = item_full_q;
  assign in_fire    = in_valid_i && !item_full_q;

  always_comb begin
    item_full_d = item_full_q;
    if (ctrl_i.release_item) begin
      item_full_d = 1'b0;
    end else if (in_fire) begin
      item_full_d = 1'b1;
    end
  end

  // Decode the character at transfer time.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      morse_q <= mck_pkg::morse_decode(in_data_i.character);
      space_q <= (in_data_i.character == mck_pkg::CharSpace);
      eom_q   <= in_data_i.end_of_message;
    end
  end

  // Element counter walks the dot/dash mask.
  assign more_elem = ({1'b0, elem_q} + 4'd1) < {1'b0, morse_q.len};
  assign is_dash   = morse_q.pat[elem_q];

  always_comb begin
    elem_d = elem_q;
    if (ctrl_i.release_item) begin
      elem_d = 3'd0;
    end else if (ctrl_i.inc_elem) begin
      elem_d = elem_q + 3'd1;
    end
  end

  // Segment duration and last flag.
  always_comb begin
    if (ctrl_i.dur == mck_pkg::DUR_ELEM) begin
      dur = is_dash ? cfg_i.dash_on : cfg_i.dot_on;
    end else begin
      dur = cfg_i.gap;
    end
  end

  always_comb begin
    case (ctrl_i.last)
      mck_pkg::LAST_NEVER:    seg_last = 1'b0;
      mck_pkg::LAST_ALWAYS:   seg_last = 1'b1;
      mck_pkg::LAST_ELEM_END: seg_last = !more_elem && !space_q && !eom_q;
      mck_pkg::LAST_NO_EOM:   seg_last = !eom_q;
      default:                seg_last = 1'b0;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_q.lamp_on        <= ctrl_i.lamp;
      out_q.duration_ticks <= dur;
      out_q.last           <= seg_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_full_q <= 1'b0;
      elem_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      item_full_q <= item_full_d;
      elem_q      <= elem_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status back to the sequencer.
  assign status_o.item_full = item_full_q;
  assign status_o.len_zero  = (morse_q.len == 3'd0);
  assign status_o.more_elem = more_elem;
  assign status_o.is_space  = space_q;
  assign status_o.eom       = eom_q;
  assign status_o.out_ready = !out_valid_q || !out_stall_i;

  // Segments are only produced for a held character.
  a_emit_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.emit |-> item_full_q)
    else $error("segment emitted without a held character");

  // A pending segment is never overwritten while stalled.
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !ctrl_i.emit)
    else $error("output register overwritten under stall");

  // The element counter ends one past the last element of the longest pattern.
  a_elem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    elem_q <= 3'd5)
    else $error("element counter out of range");

  // Releasing the character frees the input and rewinds the counter.
  a_release : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.release_item |=> (!item_full_q && elem_q == 3'd0))
    else $error("release did not free the character register");

endmodule

// ----- src/morse_code_keyer.sv -----
// Top level of the Morse keyer: timing registers, sequencer and datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one ASCII character and an
//   end-of-message flag per transfer. Letters A to Z and digits 0 to 9 become dots and
//   dashes, each followed by a dark gap; a space gives two dark gaps, the flag two more.
//   Other characters give nothing of their own.
//   Output channel (out_valid_o / out_stall_i / out_data_o) carries one lamp segment per
//   transfer; last marks the final segment caused by a character.
//   Sequence: every character runs five control steps (wait, length check, space check,
//   end-of-message check, done) plus one step per segment, and the next character is
//   taken in the wait step after that, so a new character is not taken before the last
//   one is through (a digit with end of message gives twelve segments). The first segment
//   reaches the output register after the wait, length check and first element-on steps.
//   A stalled receiver freezes the sequencer on its next emitting step; the pending
//   segment stays in the output register and nothing is lost.
//   Reset clears the sequencer and all valid flags and loads the timing registers with
//   dot 5000, dash 15000 and gap 10000 ticks. Registers sit on the APB port at byte
//   offsets 0, 4 and 8 and should be written while the keyer is idle.
module morse_code_keyer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mck_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mck_pkg::out_item_t out_data_o
);

  logic [15:0]         dot_on_q;
  logic [15:0]         dash_on_q;
  logic [15:0]         gap_q;
  logic                wr_en;
  logic [1:0]          reg_idx;
  mck_pkg::cfg_t       cfg;
  mck_pkg::dp_ctrl_t   ctrl;
  mck_pkg::dp_status_t status;

  // Register port: zero wait states.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_on_q  <= mck_pkg::DotOnReset;
      dash_on_q <= mck_pkg::DashOnReset;
      gap_q     <= mck_pkg::GapReset;
    end else if (wr_en) begin
      case (reg_idx)
        mck_pkg::REG_DOT_ON:  dot_on_q  <= pwdata[15:0];
        mck_pkg::REG_DASH_ON: dash_on_q <= pwdata[15:0];
        mck_pkg::REG_GAP:     gap_q     <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      mck_pkg::REG_DOT_ON:  prdata = {16'h0000, dot_on_q};
      mck_pkg::REG_DASH_ON: prdata = {16'h0000, dash_on_q};
      mck_pkg::REG_GAP:     prdata = {16'h0000, gap_q};
      default:              prdata = 32'h0000_0000;
    endcase
  end

  assign cfg.dot_on  = dot_on_q;
  assign cfg.dash_on = dash_on_q;
  assign cfg.gap     = gap_q;

  mck_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  mck_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .ctrl_i      (ctrl),
    .status_o    (status)
  );

endmodule
